// ===== rtl/ugc_pkg.sv =====
// Package with the shared constants and the controller state type of the connectivity checker.
package ugc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int CFG_W        = 7;
  localparam int END_W        = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_A,
    ST_WR_B,
    ST_INIT,
    ST_POP,
    ST_FETCH,
    ST_LATCH,
    ST_PUSH,
    ST_DONE
  } ugc_state_e;

endpackage

// ===== rtl/ugc_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module ugc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ugc_find_first.sv =====
// Priority encoder that finds the lowest set bit of a candidate vector.
module ugc_find_first #(
  parameter int Width = 64
) (
  input  logic [Width-1:0]         vec_i,
  output logic                     found_o,
  output logic [$clog2(Width)-1:0] idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = Width - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = ($clog2(Width))'(i);
      end
    end
  end

  assign found_o = |vec_i;

endmodule

// ===== rtl/undirected_graph_connectivity.sv =====
// Top level of the undirected graph connectivity checker: edge loading and depth-first walk.
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  ----------------------------------------
//   in        input      in_valid_i / in_stall_o   edge_valid_i, end_a_i, end_b_i, last_item_i
//   out       output     out_valid_o / out_stall_i is_connected_o
//   cfg       input      cfg_we_i                  cfg_wdata_i (vertex_count)
//
// An in-range edge holds the input while row a is read, row a written and row b read, then
// row b written; a self loop skips the row b write, any other item is taken at once. A last
// item then walks: pop, fetch, latch and push for each reachable vertex, bound by the single
// adjacency read. Reset clears the per-row valid bits, not the matrix; they drop again as each
// result is registered. A stalled result holds in the output register while new edges keep
// loading; the next walk runs, then waits in its final state until the register drains.
module undirected_graph_connectivity #(
  parameter int MaxVertices = ugc_pkg::MAX_VERTICES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ugc_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       edge_valid_i,
  input  logic [ugc_pkg::END_W-1:0]  end_a_i,
  input  logic [ugc_pkg::END_W-1:0]  end_b_i,
  input  logic                       last_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       is_connected_o
);

  import ugc_pkg::*;

  localparam int IdxW = $clog2(MaxVertices);
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam int CmpW = (CntW > CFG_W) ? CntW : CFG_W;

  ugc_state_e state_q, state_d;

  logic [CFG_W-1:0]       vcount_q, vcount_d;
  logic [IdxW-1:0]        a_idx_q, b_idx_q;
  logic                   self_q, last_q;
  logic                   rvld_q;
  logic [MaxVertices-1:0] row_vld_q, row_vld_d;
  logic [MaxVertices-1:0] visited_q, visited_d;
  logic [MaxVertices-1:0] cand_q, cand_d;
  logic [CntW-1:0]        depth_q, depth_d;
  logic                   out_vld_q, out_vld_d;
  logic                   out_q, out_d;

  logic [CmpW-1:0]        n_cnt;
  logic [CmpW-1:0]        a_ext, b_ext;
  logic [IdxW-1:0]        a_idx, b_idx;
  logic                   keep;
  logic                   accept;
  logic [MaxVertices-1:0] live_mask;
  logic [MaxVertices-1:0] adj_row;
  logic                   result;

  logic                   adj_we;
  logic [IdxW-1:0]        adj_waddr, adj_raddr;
  logic [MaxVertices-1:0] adj_wdata, adj_rdata;
  logic                   stk_we;
  logic [IdxW-1:0]        stk_waddr, stk_raddr, stk_rdata;
  logic [IdxW-1:0]        stk_wdata;

  logic                   ff_found;
  logic [IdxW-1:0]        ff_idx;
  logic [MaxVertices-1:0] ff_bit;

  // The effective vertex count saturates at the matrix size.
  always_comb begin
    if (CmpW'(vcount_q) > CmpW'(MaxVertices)) begin
      n_cnt = CmpW'(MaxVertices);
    end else begin
      n_cnt = CmpW'(vcount_q);
    end
  end

  // An edge is kept only when both endpoints lie in 1..n; vertex k lives at index k-1.
  assign a_ext  = CmpW'(end_a_i);
  assign b_ext  = CmpW'(end_b_i);
  assign a_idx  = IdxW'(a_ext - CmpW'(1));
  assign b_idx  = IdxW'(b_ext - CmpW'(1));
  assign keep   = edge_valid_i && (a_ext != '0) && (a_ext <= n_cnt) &&
                  (b_ext != '0) && (b_ext <= n_cnt);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    for (int i = 0; i < MaxVertices; i++) begin
      live_mask[i] = (CmpW'(i) < n_cnt);
    end
  end

  // A row that was never written since the last clear reads as all zeros.
  assign adj_row = rvld_q ? adj_rdata : '0;
  assign result  = &(visited_q | ~live_mask);
  assign ff_bit  = {{(MaxVertices - 1){1'b0}}, 1'b1} << ff_idx;

  ugc_ram #(
    .Width (MaxVertices),
    .Depth (MaxVertices)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  ugc_ram #(
    .Width (IdxW),
    .Depth (MaxVertices)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // The search unit picks one newly reached neighbor per cycle while the walk is in its push state.
  ugc_find_first #(
    .Width (MaxVertices)
  ) u_find_first (
    .vec_i   (cand_q),
    .found_o (ff_found),
    .idx_o   (ff_idx)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (keep) begin
            state_d = ST_WR_A;
          end else if (last_item_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_WR_A: begin
        if (!self_q) begin
          state_d = ST_WR_B;
        end else if (last_q) begin
          state_d = ST_INIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WR_B:  state_d = last_q ? ST_INIT : ST_IDLE;
      ST_INIT:  state_d = (n_cnt == '0) ? ST_DONE : ST_POP;
      ST_POP:   state_d = (depth_q == '0) ? ST_DONE : ST_FETCH;
      ST_FETCH: state_d = ST_LATCH;
      ST_LATCH: state_d = ST_PUSH;
      ST_PUSH: begin
        if (!ff_found) begin
          state_d = ST_POP;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and datapath logic.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    adj_we     = 1'b0;
    adj_waddr  = a_idx_q;
    adj_wdata  = adj_row;
    adj_raddr  = a_idx;
    stk_we     = 1'b0;
    stk_waddr  = depth_q[IdxW-1:0];
    stk_wdata  = ff_idx;
    stk_raddr  = IdxW'(depth_q - CntW'(1));
    vcount_d   = cfg_we_i ? cfg_wdata_i : vcount_q;
    row_vld_d  = row_vld_q;
    visited_d  = visited_q;
    cand_d     = cand_q;
    depth_d    = depth_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        adj_raddr = a_idx;
      end
      ST_WR_A: begin
        adj_we             = 1'b1;
        adj_waddr          = a_idx_q;
        adj_wdata          = adj_row | ({{(MaxVertices - 1){1'b0}}, 1'b1} << b_idx_q);
        row_vld_d[a_idx_q] = 1'b1;
        adj_raddr          = b_idx_q;
      end
      ST_WR_B: begin
        adj_we             = 1'b1;
        adj_waddr          = b_idx_q;
        adj_wdata          = adj_row | ({{(MaxVertices - 1){1'b0}}, 1'b1} << a_idx_q);
        row_vld_d[b_idx_q] = 1'b1;
      end
      ST_INIT: begin
        // Vertex one starts the walk: marked, and pushed when the count is not zero.
        visited_d = {{(MaxVertices - 1){1'b0}}, 1'b1};
        stk_we    = (n_cnt != '0);
        stk_waddr = '0;
        stk_wdata = '0;
        depth_d   = (n_cnt != '0) ? CntW'(1) : '0;
      end
      ST_POP: begin
        if (depth_q != '0) begin
          depth_d = depth_q - CntW'(1);
        end
      end
      ST_FETCH: begin
        adj_raddr = stk_rdata;
      end
      ST_LATCH: begin
        cand_d = adj_row & ~visited_q & live_mask;
      end
      ST_PUSH: begin
        if (ff_found) begin
          visited_d = visited_q | ff_bit;
          cand_d    = cand_q & ~ff_bit;
          if (depth_q < CntW'(MaxVertices)) begin
            stk_we  = 1'b1;
            depth_d = depth_q + CntW'(1);
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_d     = result;
          row_vld_d = '0;
          visited_d = '0;
          depth_d   = '0;
        end
      end
      default: begin
        adj_raddr = a_idx;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vcount_q  <= CFG_W'(1);
      row_vld_q <= '0;
      visited_q <= '0;
      depth_q   <= '0;
      out_vld_q <= 1'b0;
      last_q    <= 1'b0;
      self_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      vcount_q  <= vcount_d;
      row_vld_q <= row_vld_d;
      visited_q <= visited_d;
      depth_q   <= depth_d;
      out_vld_q <= out_vld_d;
      if (accept) begin
        last_q <= last_item_i;
        self_q <= (a_idx == b_idx);
      end
    end
  end

  // Payload registers; the row valid flag follows the RAM read address every cycle.
  always_ff @(posedge clk_i) begin
    rvld_q <= row_vld_q[adj_raddr];
    cand_q <= cand_d;
    out_q  <= out_d;
    if (accept) begin
      a_idx_q <= a_idx;
      b_idx_q <= b_idx;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign is_connected_o = out_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the undirected graph connectivity checker.
`timescale 1ns / 100ps

module tb_top;

  import ugc_pkg::*;

  // One edge transaction as it is presented on the input channel.
  typedef struct packed {
    logic             edge_valid;
    logic [END_W-1:0] end_a;
    logic [END_W-1:0] end_b;
    logic             last_item;
  } edge_item_t;

  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  // The settle time lets an edge write still in flight land in the matrix.
  localparam int          SETTLE_CYCLES = 10;
  localparam int          TAIL_CYCLES   = 300;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          IDLE_PERCENT  = 6;

  // Every input starts at a known value; reset is held low from time zero.
  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_we_i       = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i    = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic             edge_valid_i   = 1'b0;
  logic [END_W-1:0] end_a_i        = '0;
  logic [END_W-1:0] end_b_i        = '0;
  logic             last_item_i    = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic             is_connected_o;

  undirected_graph_connectivity DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .edge_valid_i   (edge_valid_i),
    .end_a_i        (end_a_i),
    .end_b_i        (end_b_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_connected_o (is_connected_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Predictor state: a private copy of the adjacency matrix and the vertex count register.
  // ---------------------------------------------------------------------------------------
  logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
  logic [CFG_W-1:0]        vertex_count_reg = 7'd1;

  // Connectivity answers still owed by the block, oldest first.
  bit          expected_connected [$];
  int          errors      = 0;
  int          items_sent  = 0;
  int unsigned cycle_count = 0;

  // When cleared, neither the sender nor the receiver inserts random gaps.
  bit idle_en = 1'b1;

  // The receiver's long hold-off is requested by bumping this counter; the stall process
  // notices the change and counts the hold down on its own.
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  initial begin
    for (int r = 0; r < MAX_VERTICES; r++) adj_rows[r] = '0;
  end

  // A count above the matrix size saturates at the matrix size.
  function automatic int live_count();
    return (vertex_count_reg > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_reg);
  endfunction

  // Depth-first walk from vertex one (row zero) with a bounded explicit stack. Each vertex
  // is pushed at most once, so the stack never overflows, but the bound is kept anyway.
  function automatic bit walk_reaches_all();
    int                      n;
    int                      stack [MAX_VERTICES];
    int                      depth;
    int                      v;
    logic [MAX_VERTICES-1:0] seen;
    n = live_count();
    if (n == 0) return 1'b1;
    seen     = '0;
    seen[0]  = 1'b1;
    stack[0] = 0;
    depth    = 1;
    while (depth > 0) begin
      depth--;
      v = stack[depth];
      for (int w = 0; w < n; w++) begin
        if (adj_rows[v][w] && !seen[w]) begin
          seen[w] = 1'b1;
          if (depth < MAX_VERTICES) begin
            stack[depth] = w;
            depth++;
          end
        end
      end
    end
    for (int w = 0; w < n; w++) begin
      if (!seen[w]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one accepted transaction to the predictor. The edge of a last item is stored
  // before the walk, and the matrix is wiped once the answer is known.
  function automatic void predict_item(edge_item_t it);
    int n;
    n = live_count();
    if (it.edge_valid && it.end_a >= 1 && it.end_a <= n && it.end_b >= 1 && it.end_b <= n)
    begin
      adj_rows[it.end_a - 1][it.end_b - 1] = 1'b1;
      adj_rows[it.end_b - 1][it.end_a - 1] = 1'b1;
    end
    if (it.last_item) begin
      expected_connected = {expected_connected, walk_reaches_all()};
      for (int r = 0; r < MAX_VERTICES; r++) adj_rows[r] = '0;
    end
  endfunction

  function automatic edge_item_t make_item(bit valid, int a, int b, bit last);
    edge_item_t it;
    it.edge_valid = valid;
    it.end_a      = END_W'(a);
    it.end_b      = END_W'(b);
    it.last_item  = last;
    return it;
  endfunction

  // An item that the block must ignore: either no edge at all, or an edge with at least one
  // endpoint of zero or beyond the current vertex count (up to the full field range).
  function automatic edge_item_t make_ignored_item(int n, bit last);
    int good;
    int bad;
    good = (n >= 1) ? $urandom_range(1, n) : 1;
    bad  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(n + 1, 127);
    case ($urandom_range(0, 2))
      0:       return make_item(1'b0, $urandom_range(0, 127), $urandom_range(0, 127), last);
      1:       return make_item(1'b1, bad, good, last);
      default: return make_item(1'b1, good, bad, last);
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving side. Inputs change only at the falling edge; acceptance is judged at the
  // rising edge, when in_valid_i is high and in_stall_o is low.
  // ---------------------------------------------------------------------------------------
  task automatic send_item(edge_item_t it);
    @(negedge clk_i);
    while (idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    edge_valid_i <= it.edge_valid;
    end_a_i      <= it.end_a;
    end_b_i      <= it.end_b;
    last_item_i  <= it.last_item;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(it);
    items_sent++;
  endtask

  // Stops offering transactions and waits until every owed answer has been taken, then
  // lets the block finish any edge write still in flight.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_connected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The register is only touched while the block is idle.
  task automatic write_count(int value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    vertex_count_reg = CFG_W'(value);
  endtask

  // Mostly small counts, with the extremes and the saturating range mixed in.
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 0;
    if (r < 8)  return 127;
    if (r < 12) return MAX_VERTICES;
    if (r < 15) return $urandom_range(MAX_VERTICES + 1, 126);
    if (r < 22) return $urandom_range(17, MAX_VERTICES - 1);
    return $urandom_range(1, 16);
  endfunction

  // One random graph for the current count, finished by a last item. About half of the
  // graphs are spanning trees (connected), some are trees with one edge dropped (usually
  // split), and the rest are sparse random edge sets. Ignored items are sprinkled in.
  task automatic send_random_graph();
    int n;
    int kind;
    int pick;
    int tmp;
    int order [MAX_VERTICES];
    int ea [$];
    int eb [$];
    int a;
    int b;
    n    = live_count();
    kind = $urandom_range(0, 3);
    if (kind <= 2) begin
      for (int i = 0; i < n; i++) order[i] = i + 1;
      for (int i = n - 1; i > 0; i--) begin
        pick        = $urandom_range(0, i);
        tmp         = order[i];
        order[i]    = order[pick];
        order[pick] = tmp;
      end
      for (int i = 1; i < n; i++) begin
        ea = {ea, order[i]};
        eb = {eb, order[$urandom_range(0, i - 1)]};
      end
      if (kind == 2 && ea.size() != 0) begin
        pick = $urandom_range(0, ea.size() - 1);
        ea.delete(pick);
        eb.delete(pick);
      end
    end else if (n >= 1) begin
      repeat ($urandom_range(0, 2 * n)) begin
        ea = {ea, int'($urandom_range(1, n))};
        eb = {eb, int'($urandom_range(1, n))};
      end
    end
    while (ea.size() > 1 || (ea.size() == 1 && $urandom_range(0, 1) == 0)) begin
      if ($urandom_range(0, 9) == 0) send_item(make_ignored_item(n, 1'b0));
      a = ea.pop_front();
      b = eb.pop_front();
      if ($urandom_range(0, 1)) send_item(make_item(1'b1, a, b, 1'b0));
      else                      send_item(make_item(1'b1, b, a, 1'b0));
    end
    // The closing item carries the final edge or nothing that counts.
    if (ea.size() != 0) send_item(make_item(1'b1, ea.pop_front(), eb.pop_front(), 1'b1));
    else                send_item(make_ignored_item(n, 1'b1));
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // After reset the count is one, so a lone vertex with no edges is connected.
  task automatic test_reset_count();
    send_item(make_item(1'b0, 0, 0, 1'b1));
  endtask

  // A count of zero keeps no edge and always reports connected; a count above the matrix
  // size behaves as the full 64 vertices.
  task automatic test_count_extremes();
    write_count(0);
    send_item(make_item(1'b1, 1, 1, 1'b1));
    write_count(127);
    send_item(make_item(1'b1, MAX_VERTICES, MAX_VERTICES + 1, 1'b0));
    send_item(make_item(1'b1, 1, MAX_VERTICES, 1'b1));
  endtask

  // Endpoints of zero, past the count or at the field maximum are dropped, as is an item
  // without an edge. The last item's own edge still counts before the walk.
  task automatic test_endpoint_range();
    write_count(2);
    send_item(make_item(1'b1, 0, 1, 1'b0));
    send_item(make_item(1'b1, 2, 3, 1'b0));
    send_item(make_item(1'b1, 127, 1, 1'b0));
    send_item(make_item(1'b0, 1, 2, 1'b0));
    send_item(make_item(1'b0, 1, 2, 1'b1));
    send_item(make_item(1'b1, 1, 2, 1'b1));
  endtask

  // Self loops are stored but never join two vertices.
  task automatic test_self_loops();
    write_count(3);
    send_item(make_item(1'b1, 1, 1, 1'b0));
    send_item(make_item(1'b1, 1, 2, 1'b0));
    send_item(make_item(1'b1, 3, 3, 1'b0));
    send_item(make_item(1'b1, 3, 2, 1'b1));
    send_item(make_item(1'b1, 2, 2, 1'b0));
    send_item(make_item(1'b1, 1, 3, 1'b1));
  endtask

  // The count may change while a graph is half loaded: edges are filtered by the count at
  // their arrival, and the walk only scans vertices up to the count at the last item.
  task automatic test_count_change_midgraph();
    write_count(2);
    send_item(make_item(1'b1, 1, 2, 1'b0));
    write_count(3);
    send_item(make_item(1'b1, 2, 3, 1'b1));
    write_count(4);
    send_item(make_item(1'b1, 3, 4, 1'b0));
    send_item(make_item(1'b1, 1, 2, 1'b0));
    write_count(2);
    send_item(make_item(1'b0, 0, 0, 1'b1));
  endtask

  // Random graphs in groups, with a fresh count before each group.
  task automatic test_random_graphs(int item_goal);
    int start;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      write_count(pick_count());
      repeat ($urandom_range(2, 6)) send_random_graph();
    end
    drain_results();
  endtask

  // The same random traffic with neither side ever pausing.
  task automatic test_no_idle(int item_goal);
    idle_en = 1'b0;
    test_random_graphs(item_goal);
    idle_en = 1'b1;
  endtask

  // The receiver refuses results for a long stretch while small graphs keep arriving, so
  // the held result blocks the next one and the input channel backs up. The sender then
  // waits for every answer before going on.
  task automatic test_backpressure();
    write_count($urandom_range(3, 8));
    hold_requests++;
    repeat (12) send_random_graph();
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_count();
    test_count_extremes();
    test_endpoint_range();
    test_self_loops();
    test_count_change_midgraph();
    test_random_graphs(950);
    test_backpressure();
    test_no_idle(250);
    test_random_graphs(100);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_connected.size() == 0) begin
      $display("undirected_graph_connectivity test passed");
    end else begin
      $display("undirected_graph_connectivity test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Receiving side: random stall at the falling edge, plus the requested long hold-off.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // Every accepted result is matched against the oldest owed answer.
  always @(posedge clk_i) begin : check_results
    bit want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_connected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual is_connected=%0b",
                 $time, is_connected_o);
      end else begin
        want = expected_connected.pop_front();
        if (is_connected_o !== want) begin
          errors++;
          $display("%0t: is_connected mismatch, expected %0b, actual %0b",
                   $time, want, is_connected_o);
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("undirected_graph_connectivity test failed");
      $finish;
    end
  end

endmodule
